// ===== design/fdo_pkg.sv =====
package fdo_pkg;

   // port widths
   localparam int COORD_W    = 14;
   localparam int VALUE_W    = 32;
   localparam int CLASS_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // text geometry
   localparam int CELL_SCALE = 3;
   localparam int MAX_DIGITS = 10;
   localparam int TEXT_INSET = 14;
   localparam int BOX_MARGIN = 6;
   localparam int GLYPH_W    = 5;
   localparam int GLYPH_H    = 7;
   localparam int ADVANCE    = (GLYPH_W + 1) * CELL_SCALE;
   localparam int TEXT_W_MAX = MAX_DIGITS * ADVANCE - CELL_SCALE;

   localparam int DX_W       = $clog2(TEXT_W_MAX + BOX_MARGIN);
   localparam int DY_W       = $clog2(GLYPH_H * CELL_SCALE + BOX_MARGIN);
   localparam int GEO_W      = COORD_W + 2;
   localparam int N_W        = $clog2(MAX_DIGITS + 1);
   localparam int ROW_W      = $clog2(GLYPH_H + 1);
   localparam int COL_W      = $clog2(GLYPH_W + 1);
   localparam int FONT_ROW_W = $clog2(GLYPH_H);
   localparam int FONT_BIT_W = $clog2(GLYPH_W);

   // binary to BCD conversion, spread over four stages
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int POS_W      = $clog2(BCD_DIGITS);
   localparam int DD_STAGES  = 4;
   localparam int DD_STEPS   = VALUE_W / DD_STAGES;

   localparam int RESET_VIEWPORT_RIGHT = 1920;

   typedef logic signed [GEO_W-1:0] geo_type;

   typedef struct packed {
      logic [BCD_W-1:0]   bcd;
      logic [VALUE_W-1:0] bin;
   } dd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OVERLAY_ENABLE = 2'd0,
      CSR_VIEWPORT_RIGHT = 2'd1,
      CSR_VIEWPORT_TOP   = 2'd2
   } csr_index_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_UNTOUCHED  = 2'd0,
      CLASS_BACKGROUND = 2'd1,
      CLASS_FOREGROUND = 2'd2
   } pixel_class_type;

   localparam logic [VALUE_W-1:0] POW10 [BCD_DIGITS] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
      32'd10000000, 32'd100000000, 32'd1000000000
   };

   localparam logic [GLYPH_W-1:0] DIGIT_ROWS [BCD_DIGITS][GLYPH_H] = '{
      '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
      '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
      '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
      '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
      '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
      '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
      '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
      '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
      '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
      '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
   };

   // decimal digit count, no leading zeros, capped
   function automatic logic [N_W-1:0] digit_count(logic [VALUE_W-1:0] v);
      logic [N_W-1:0] n;
      n = N_W'(1);
      for (int k = 1; k < BCD_DIGITS; k++) begin
         if (k < MAX_DIGITS && v >= POW10[k]) begin
            n = N_W'(k + 1);
         end
      end
      return n;
   endfunction

   // text width for n digits
   function automatic geo_type text_width(logic [N_W-1:0] n);
      return geo_type'(int'(n) * ADVANCE - CELL_SCALE);
   endfunction

   // pixel_x - origin_x = pixel_x - right + width + inset
   function automatic geo_type text_offset(logic [N_W-1:0] n);
      return geo_type'(int'(n) * ADVANCE - CELL_SCALE + TEXT_INSET);
   endfunction

   // shift-and-add-3 steps for one stage
   function automatic dd_type dabble_steps(dd_type s_in);
      dd_type s;
      s = s_in;
      for (int i = 0; i < DD_STEPS; i++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (s.bcd[4*d +: 4] >= 4'd5) begin
               s.bcd[4*d +: 4] = s.bcd[4*d +: 4] + 4'd3;
            end
         end
         s.bcd = {s.bcd[BCD_W-2:0], s.bin[VALUE_W-1]};
         s.bin = {s.bin[VALUE_W-2:0], 1'b0};
      end
      return s;
   endfunction

   function automatic logic bcd_valid(logic [BCD_W-1:0] bcd);
      logic ok;
      ok = 1'b1;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd[4*d +: 4] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

// ===== design/fdo_if.sv =====
interface fdo_req_if;
   logic                         valid;
   logic                         ready;
   logic [fdo_pkg::COORD_W-1:0]  pixel_x;
   logic [fdo_pkg::COORD_W-1:0]  pixel_y;
   logic [fdo_pkg::VALUE_W-1:0]  shown_value;

   modport source (output valid, output pixel_x, output pixel_y, output shown_value,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input shown_value,
                   output ready);
endinterface

interface fdo_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fdo_pkg::CLASS_W-1:0]  pixel_class;

   modport source (output valid, output pixel_class, input ready);
   modport sink   (input valid, input pixel_class, output ready);
endinterface

// ===== design/fps_digit_overlay_pixel_classifier.sv =====
// channel   | dir | handshake     | payload
// ----------+-----+---------------+-----------------------------------------
// req_chan  | in  | valid/ready   | pixel_x[13:0] pixel_y[13:0] shown_value[31:0]
// rsp_chan  | out | valid/ready   | pixel_class[1:0]
// csr_*     | in  | write enable  | csr_index[1:0] csr_write_data[13:0]
//
// One pixel per cycle while rsp is not stalled; six register stages, s1 to s6,
// lie between a taken request and its result. Digit extraction (8 shift-add-3
// steps per stage over four stages) sets the depth.
// Reset (synchronous) empties the pipeline and restores the register defaults.
// A stall at rsp freezes every stage; ready goes low only while the output
// stage is full and not being taken.
module fps_digit_overlay_pixel_classifier (
   input  logic                             clock,
   input  logic                             reset,
   fdo_req_if.sink                          req_chan,
   fdo_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [fdo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fdo_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   // control registers
   logic                          overlay_enable_ff;
   logic [fdo_pkg::COORD_W-1:0]   viewport_right_ff;
   logic [fdo_pkg::COORD_W-1:0]   viewport_top_ff;

   logic adv;

   // stage 1
   logic                          s1_valid_ff;
   logic [fdo_pkg::COORD_W-1:0]   s1_px_ff;
   logic [fdo_pkg::COORD_W-1:0]   s1_py_ff;
   logic [fdo_pkg::VALUE_W-1:0]   s1_val_ff;
   logic [fdo_pkg::N_W-1:0]       s1_n_ff;
   logic [fdo_pkg::N_W-1:0]       s1_n_in;

   // stage 2
   logic                          s2_valid_ff;
   fdo_pkg::dd_type               s2_dd_ff;
   fdo_pkg::dd_type               s2_dd_in;
   fdo_pkg::dd_type               dd_seed;
   logic [fdo_pkg::N_W-1:0]       s2_n_ff;
   logic                          s2_box_ff;
   logic                          s2_box_in;
   logic                          s2_text_ff;
   logic                          s2_text_in;
   logic [fdo_pkg::DX_W-1:0]      s2_dx_ff;
   logic [fdo_pkg::DY_W-1:0]      s2_dy_ff;
   fdo_pkg::geo_type              dx_full;
   fdo_pkg::geo_type              dy_full;

   // stage 3
   logic                          s3_valid_ff;
   fdo_pkg::dd_type               s3_dd_ff;
   logic [fdo_pkg::N_W-1:0]       s3_n_ff;
   logic                          s3_box_ff;
   logic                          s3_glyph_ok_ff;
   logic                          s3_glyph_ok_in;
   logic [fdo_pkg::POS_W-1:0]     s3_pos_ff;
   logic [fdo_pkg::POS_W-1:0]     s3_pos_in;
   logic [fdo_pkg::DX_W-1:0]      s3_dx_ff;
   logic [fdo_pkg::N_W-1:0]       s3_g_ff;
   logic [fdo_pkg::N_W-1:0]       s3_g_in;
   logic [fdo_pkg::ROW_W-1:0]     s3_row_ff;
   logic [fdo_pkg::ROW_W-1:0]     s3_row_in;

   // stage 4
   logic                          s4_valid_ff;
   fdo_pkg::dd_type               s4_dd_ff;
   logic [fdo_pkg::N_W-1:0]       s4_n_ff;
   logic                          s4_box_ff;
   logic                          s4_dot_ok_ff;
   logic                          s4_dot_ok_in;
   logic [fdo_pkg::POS_W-1:0]     s4_pos_ff;
   logic [fdo_pkg::ROW_W-1:0]     s4_row_ff;
   logic [fdo_pkg::COL_W-1:0]     s4_col_ff;
   logic [fdo_pkg::COL_W-1:0]     s4_col_in;
   logic [fdo_pkg::DX_W-1:0]      glyph_rem;

   // stage 5
   logic                          s5_valid_ff;
   fdo_pkg::dd_type               s5_dd_ff;
   logic [fdo_pkg::N_W-1:0]       s5_n_ff;
   logic                          s5_box_ff;
   logic                          s5_dot_ok_ff;
   logic [fdo_pkg::POS_W-1:0]     s5_pos_ff;
   logic [fdo_pkg::FONT_ROW_W-1:0] s5_row_ff;
   logic [fdo_pkg::FONT_BIT_W-1:0] s5_col_ff;

   // stage 6, output
   logic                          s6_valid_ff;
   fdo_pkg::pixel_class_type      s6_class_ff;
   fdo_pkg::pixel_class_type      s6_class_in;
   logic [3:0]                    digit;
   logic [fdo_pkg::GLYPH_W-1:0]   font_bits;
   logic                          lit;

   assign adv            = !s6_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = s6_valid_ff;
   assign rsp_chan.pixel_class = s6_class_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         overlay_enable_ff <= 1'b1;
         viewport_right_ff <= fdo_pkg::COORD_W'(fdo_pkg::RESET_VIEWPORT_RIGHT);
         viewport_top_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            fdo_pkg::CSR_OVERLAY_ENABLE: begin
               overlay_enable_ff <= csr_write_data[0];
            end
            fdo_pkg::CSR_VIEWPORT_RIGHT: begin
               viewport_right_ff <= csr_write_data[fdo_pkg::COORD_W-1:0];
            end
            fdo_pkg::CSR_VIEWPORT_TOP: begin
               viewport_top_ff <= csr_write_data[fdo_pkg::COORD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // stage 1: capture, digit count
   assign s1_n_in = fdo_pkg::digit_count(req_chan.shown_value);

   // stage 2: box test and offsets into the text, first BCD slice
   always_comb begin
      dd_seed.bcd = '0;
      dd_seed.bin = s1_val_ff;
      s2_dd_in    = fdo_pkg::dabble_steps(dd_seed);
      dx_full = fdo_pkg::geo_type'(s1_px_ff) - fdo_pkg::geo_type'(viewport_right_ff)
              + fdo_pkg::text_offset(s1_n_ff);
      dy_full = fdo_pkg::geo_type'(s1_py_ff) - fdo_pkg::geo_type'(viewport_top_ff)
              - fdo_pkg::geo_type'(fdo_pkg::TEXT_INSET);
      s2_box_in = overlay_enable_ff
         && dx_full >= fdo_pkg::geo_type'(-fdo_pkg::BOX_MARGIN)
         && dx_full <  fdo_pkg::text_width(s1_n_ff) + fdo_pkg::geo_type'(fdo_pkg::BOX_MARGIN)
         && dy_full >= fdo_pkg::geo_type'(-fdo_pkg::BOX_MARGIN)
         && dy_full <  fdo_pkg::geo_type'(fdo_pkg::GLYPH_H * fdo_pkg::CELL_SCALE
                                          + fdo_pkg::BOX_MARGIN);
      s2_text_in = s2_box_in && !dx_full[fdo_pkg::GEO_W-1] && !dy_full[fdo_pkg::GEO_W-1];
   end

   // stage 3: glyph index and dot row by threshold compare
   always_comb begin
      s3_g_in   = '0;
      s3_row_in = '0;
      for (int k = 1; k <= fdo_pkg::MAX_DIGITS; k++) begin
         if (int'(s2_dx_ff) >= k * fdo_pkg::ADVANCE) begin
            s3_g_in = fdo_pkg::N_W'(k);
         end
      end
      for (int r = 1; r <= fdo_pkg::GLYPH_H; r++) begin
         if (int'(s2_dy_ff) >= r * fdo_pkg::CELL_SCALE) begin
            s3_row_in = fdo_pkg::ROW_W'(r);
         end
      end
      s3_glyph_ok_in = s2_text_ff && (s3_g_in < s2_n_ff)
                    && (s3_row_in < fdo_pkg::ROW_W'(fdo_pkg::GLYPH_H));
      // digit place counted from the least significant end
      s3_pos_in = fdo_pkg::POS_W'(s2_n_ff - fdo_pkg::N_W'(1) - s3_g_in);
   end

   // stage 4: dot column inside the glyph
   always_comb begin
      glyph_rem = s3_dx_ff - fdo_pkg::DX_W'(int'(s3_g_ff) * fdo_pkg::ADVANCE);
      s4_col_in = '0;
      for (int c = 1; c <= fdo_pkg::GLYPH_W; c++) begin
         if (int'(glyph_rem) >= c * fdo_pkg::CELL_SCALE) begin
            s4_col_in = fdo_pkg::COL_W'(c);
         end
      end
      s4_dot_ok_in = s3_glyph_ok_ff && (s4_col_in < fdo_pkg::COL_W'(fdo_pkg::GLYPH_W));
   end

   // stage 6: digit pick, font lookup, class
   always_comb begin
      digit     = s5_dd_ff.bcd[4*s5_pos_ff +: 4];
      font_bits = fdo_pkg::DIGIT_ROWS[digit][s5_row_ff];
      lit       = s5_dot_ok_ff
               && font_bits[fdo_pkg::FONT_BIT_W'(fdo_pkg::GLYPH_W - 1) - s5_col_ff];
      if (lit) begin
         s6_class_in = fdo_pkg::CLASS_FOREGROUND;
      end else if (s5_box_ff) begin
         s6_class_in = fdo_pkg::CLASS_BACKGROUND;
      end else begin
         s6_class_in = fdo_pkg::CLASS_UNTOUCHED;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff  <= req_chan.pixel_x;
         s1_py_ff  <= req_chan.pixel_y;
         s1_val_ff <= req_chan.shown_value;
         s1_n_ff   <= s1_n_in;

         s2_dd_ff   <= s2_dd_in;
         s2_n_ff    <= s1_n_ff;
         s2_box_ff  <= s2_box_in;
         s2_text_ff <= s2_text_in;
         s2_dx_ff   <= dx_full[fdo_pkg::DX_W-1:0];
         s2_dy_ff   <= dy_full[fdo_pkg::DY_W-1:0];

         s3_dd_ff       <= fdo_pkg::dabble_steps(s2_dd_ff);
         s3_n_ff        <= s2_n_ff;
         s3_box_ff      <= s2_box_ff;
         s3_glyph_ok_ff <= s3_glyph_ok_in;
         s3_pos_ff      <= s3_pos_in;
         s3_dx_ff       <= s2_dx_ff;
         s3_g_ff        <= s3_g_in;
         s3_row_ff      <= s3_row_in;

         s4_dd_ff     <= fdo_pkg::dabble_steps(s3_dd_ff);
         s4_n_ff      <= s3_n_ff;
         s4_box_ff    <= s3_box_ff;
         s4_dot_ok_ff <= s4_dot_ok_in;
         s4_pos_ff    <= s3_pos_ff;
         s4_row_ff    <= s3_row_ff;
         s4_col_ff    <= s4_col_in;

         s5_dd_ff     <= fdo_pkg::dabble_steps(s4_dd_ff);
         s5_n_ff      <= s4_n_ff;
         s5_box_ff    <= s4_box_ff;
         s5_dot_ok_ff <= s4_dot_ok_ff;
         s5_pos_ff    <= s4_pos_ff;
         s5_row_ff    <= s4_row_ff[fdo_pkg::FONT_ROW_W-1:0];
         s5_col_ff    <= s4_col_ff[fdo_pkg::FONT_BIT_W-1:0];

         s6_class_ff <= s6_class_in;
      end
   end

   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> fdo_pkg::bcd_valid(s5_dd_ff.bcd))
      else $error("BCD conversion produced a digit above nine");

   // compare-based digit count must agree with the converted leading digit
   a_leading_digit: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && s5_n_ff > fdo_pkg::N_W'(1)
         && s5_n_ff < fdo_pkg::N_W'(fdo_pkg::MAX_DIGITS)
      |-> s5_dd_ff.bcd[4*(s5_n_ff - fdo_pkg::N_W'(1)) +: 4] != 4'd0)
      else $error("digit count disagrees with BCD leading digit");

   a_dot_in_box: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && s5_dot_ok_ff |-> s5_box_ff && s5_pos_ff < s5_n_ff)
      else $error("glyph dot outside the background box or digit range");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result presented straight after reset");

endmodule
